// ===== hdl/chu_time_code_frame_decoder_macros.svh =====
// Assertion macros shared by the CHU time code frame decoder modules.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef CHU_TIME_CODE_FRAME_DECODER_MACROS_SVH
`define CHU_TIME_CODE_FRAME_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define CTD_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

`define CTD_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define CTD_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)

`define CTD_ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ===== hdl/ctd_pkg.sv =====
// Shared types, constants and decode functions of the CHU time code frame decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package ctd_pkg;

    localparam int FRAME_LEN = 10;
    localparam int HALF_LEN  = FRAME_LEN / 2;
    localparam int COUNT_W   = $clog2(FRAME_LEN);

    localparam logic [COUNT_W-1:0] LAST_INDEX = COUNT_W'(FRAME_LEN - 1);

    localparam logic       OP_DATA   = 1'b0;
    localparam logic       OP_RESYNC = 1'b1;

    localparam logic [1:0] KIND_A      = 2'd0;
    localparam logic [1:0] KIND_B      = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    localparam logic [3:0]        A_MARKER      = 4'h6;
    localparam logic signed [6:0] OFFSET_RESET  = 7'sd2;

    typedef struct packed {
        logic store_byte;
        logic clear_count;
        logic load_result;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last_byte;
        logic out_free;
    } t_ctrl_status;

    // Two BCD digits of a byte after its nibbles are swapped: the low nibble
    // is the tens digit and the high nibble the units digit.
    function automatic logic [7:0] swapped_bcd2(input logic [7:0] t);
        return ({4'd0, t[3:0]} * 8'd10) + {4'd0, t[7:4]};
    endfunction

endpackage

// ===== hdl/chu_time_code_frame_decoder.sv =====
// Decoder for frames of the CHU radio time code. Each accepted transaction
// carries one demodulated byte or a resync; ten bytes make a frame. The
// byte that completes a frame is followed by a decode state in which the
// input is stalled and the frame is checked and decoded in parallel into the
// result register; that state lasts for as long as a previous result is still
// stalled at the output. Top level; depends on ctd_pkg, ctd_ctrl and
// ctd_datapath.
module chu_time_code_frame_decoder import ctd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_op,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_wr_en,
    input  logic signed [6:0]  i_cfg_wr_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_kind,
    output logic [10:0]        o_day_of_year,
    output logic [7:0]         o_hour_value,
    output logic [7:0]         o_minute_value,
    output logic signed [8:0]  o_second_value,
    output logic [14:0]        o_year_value,
    output logic [3:0]         o_dut1_value,
    output logic [7:0]         o_tai_utc_value,
    output logic [3:0]         o_dst_code
);

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    ctd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    ctd_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_data_byte     (i_data_byte),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_kind          (o_kind),
        .o_day_of_year   (o_day_of_year),
        .o_hour_value    (o_hour_value),
        .o_minute_value  (o_minute_value),
        .o_second_value  (o_second_value),
        .o_year_value    (o_year_value),
        .o_dut1_value    (o_dut1_value),
        .o_tai_utc_value (o_tai_utc_value),
        .o_dst_code      (o_dst_code)
    );

endmodule

// ===== hdl/ctd_ctrl.sv =====
// Controller state machine of the CHU time code frame decoder.
// Depends on ctd_pkg and the assertion macro header.
`include "chu_time_code_frame_decoder_macros.svh"

module ctd_ctrl import ctd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_op,
    input  t_ctrl_status i_status,
    output t_ctrl_cmd    o_cmd,
    output logic         o_in_stall
);

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_DECODE  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state           = r_state;
        o_cmd.store_byte  = 1'b0;
        o_cmd.clear_count = 1'b0;
        o_cmd.load_result = 1'b0;
        o_in_stall        = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                if (i_in_valid) begin
                    if (i_op == OP_RESYNC) begin
                        o_cmd.clear_count = 1'b1;
                    end else begin
                        o_cmd.store_byte = 1'b1;
                        if (i_status.last_byte) begin
                            n_state = ST_DECODE;
                        end
                    end
                end
            end
            ST_DECODE: begin
                o_in_stall = 1'b1;
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    `CTD_ASSERT_NEXT(a_last_byte_decodes, i_clk, i_rst_n,
        o_cmd.store_byte && i_status.last_byte, r_state == ST_DECODE)
    `CTD_ASSERT_IMPLIES(a_no_store_in_decode, i_clk, i_rst_n,
        r_state == ST_DECODE, !o_cmd.store_byte && !o_cmd.clear_count)
    `CTD_ASSERT_IMPLIES(a_load_needs_free, i_clk, i_rst_n,
        o_cmd.load_result, i_status.out_free)

endmodule

// ===== hdl/ctd_datapath.sv =====
// Datapath of the CHU time code frame decoder: frame buffer, byte count, stored
// year, seconds offset, frame decode and result register. Depends on ctd_pkg.
`include "chu_time_code_frame_decoder_macros.svh"

module ctd_datapath import ctd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_ctrl_status       o_status,
    input  logic [7:0]         i_data_byte,
    input  logic               i_cfg_wr_en,
    input  logic signed [6:0]  i_cfg_wr_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_kind,
    output logic [10:0]        o_day_of_year,
    output logic [7:0]         o_hour_value,
    output logic [7:0]         o_minute_value,
    output logic signed [8:0]  o_second_value,
    output logic [14:0]        o_year_value,
    output logic [3:0]         o_dut1_value,
    output logic [7:0]         o_tai_utc_value,
    output logic [3:0]         o_dst_code
);

    logic [7:0]         r_frame [FRAME_LEN];
    logic [COUNT_W-1:0] r_count;
    logic [14:0]        r_stored_year;
    logic signed [6:0]  r_offset;
    logic               r_out_valid;

    logic               pairs_ok;
    logic               is_b;
    logic               accept_a;
    logic [1:0]         n_kind;
    logic [10:0]        n_day;
    logic [7:0]         n_hour;
    logic [7:0]         n_minute;
    logic signed [8:0]  n_second;
    logic [14:0]        n_year;
    logic [14:0]        decoded_year;
    logic [3:0]         n_dut1;
    logic [7:0]         n_tai_utc;
    logic [3:0]         n_dst;

    assign o_status.last_byte = (r_count == LAST_INDEX);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid        = r_out_valid;

    always_comb begin
        pairs_ok = 1'b1;
        for (int i = 0; i < HALF_LEN; i++) begin
            if ((r_frame[i] != r_frame[i+HALF_LEN]) && (r_frame[i] != ~r_frame[i+HALF_LEN])) begin
                pairs_ok = 1'b0;
            end
        end
        is_b         = (r_frame[HALF_LEN-1] == ~r_frame[FRAME_LEN-1]);
        accept_a     = (r_frame[0][3:0] == A_MARKER);
        decoded_year = (15'(swapped_bcd2(r_frame[1])) * 15'd100)
                     + 15'(swapped_bcd2(r_frame[2]));

        n_kind    = KIND_REJECT;
        n_day     = '0;
        n_hour    = '0;
        n_minute  = '0;
        n_second  = '0;
        n_year    = '0;
        n_dut1    = '0;
        n_tai_utc = '0;
        n_dst     = '0;
        if (pairs_ok) begin
            if (is_b) begin
                n_kind    = KIND_B;
                n_year    = decoded_year;
                n_dut1    = r_frame[0][7:4];
                n_tai_utc = swapped_bcd2(r_frame[3]);
                n_dst     = r_frame[4][7:4];
            end else if (accept_a) begin
                n_kind   = KIND_A;
                n_day    = (11'(r_frame[0][7:4]) * 11'd100) + 11'(swapped_bcd2(r_frame[1]));
                n_hour   = swapped_bcd2(r_frame[2]);
                n_minute = swapped_bcd2(r_frame[3]);
                n_second = $signed({1'b0, swapped_bcd2(r_frame[4])})
                         + $signed({{2{r_offset[6]}}, r_offset});
                n_year   = r_stored_year;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_byte) begin
            r_frame[r_count] <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_stored_year <= '0;
            r_offset      <= OFFSET_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.store_byte) begin
                r_count <= o_status.last_byte ? '0 : r_count + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_offset <= i_cfg_wr_data;
            end
            if (i_cmd.load_result && pairs_ok && is_b) begin
                r_stored_year <= decoded_year;
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_kind          <= n_kind;
            o_day_of_year   <= n_day;
            o_hour_value    <= n_hour;
            o_minute_value  <= n_minute;
            o_second_value  <= n_second;
            o_year_value    <= n_year;
            o_dut1_value    <= n_dut1;
            o_tai_utc_value <= n_tai_utc;
            o_dst_code      <= n_dst;
        end
    end

    `CTD_ASSERT_IMPLIES(a_count_in_range, i_clk, i_rst_n,
        1'b1, r_count <= LAST_INDEX)
    `CTD_ASSERT_NEXT(a_load_shows_result, i_clk, i_rst_n,
        i_cmd.load_result, r_out_valid)
    `CTD_ASSERT_NEXT(a_stalled_result_holds, i_clk, i_rst_n,
        r_out_valid && i_out_stall && !i_cmd.load_result,
        r_out_valid && $stable(o_kind) && $stable(o_year_value))

endmodule

// ===== test/chu_time_code_frame_decoder_test.sv =====
// Self-checking testbench for chu_time_code_frame_decoder: directed CHU frames, then random
// frames and noise under three idling schemes, checked against an in-bench frame decoder.
// Depends on ctd_pkg and the RTL of the block.
module chu_time_code_frame_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ctd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 420;
    localparam int SETTLE_CYCLES   = 4;

    typedef struct {
        logic [1:0]        kind;
        logic [10:0]       day;
        logic [7:0]        hour;
        logic [7:0]        minute;
        logic signed [8:0] second;
        logic [14:0]       year;
        logic [3:0]        dut1;
        logic [7:0]        tai_utc;
        logic [3:0]        dst;
    } t_frame_result;

    class chu_frame_scoreboard;
        bit [7:0]      frame_buf [FRAME_LEN];
        int            fill;
        int            offset_val;
        bit [14:0]     last_year;
        int            errors;
        int            items;
        int            kind_count [3];
        t_frame_result frames_due [$];

        function new();
            fill = 0;
            offset_val = OFFSET_RESET;
            last_year = '0;
            errors = 0;
            items = 0;
            kind_count = '{0, 0, 0};
        endfunction

        function void set_offset(int value);
            offset_val = value;
        endfunction

        static function int digit_pair(bit [7:0] v);
            return v[7:4] * 10 + v[3:0];
        endfunction

        function void note_byte(logic op, logic [7:0] data_val);
            t_frame_result r;
            bit [7:0]      sw [HALF_LEN];
            bit            type_b;
            bit            broken;
            int            sec;
            int            yr;
            items++;
            if (op == OP_RESYNC) begin
                fill = 0;
                return;
            end
            frame_buf[fill] = data_val;
            fill++;
            if (fill < FRAME_LEN) return;
            fill = 0;
            r = '{default: '0};
            r.kind = KIND_REJECT;
            type_b = 1'b0;
            broken = 1'b0;
            for (int i = 0; i < HALF_LEN; i++) begin
                if (frame_buf[i] == ~frame_buf[i + HALF_LEN]) type_b = 1'b1;
                else if (frame_buf[i] == frame_buf[i + HALF_LEN]) type_b = 1'b0;
                else broken = 1'b1;
                sw[i] = {frame_buf[i][3:0], frame_buf[i][7:4]};
            end
            if (!broken && !type_b) begin
                if (sw[0][7:4] == A_MARKER) begin
                    sec = digit_pair(sw[4]) + offset_val;
                    r.kind = KIND_A;
                    r.day = 11'(sw[0][3:0] * 100 + digit_pair(sw[1]));
                    r.hour = 8'(digit_pair(sw[2]));
                    r.minute = 8'(digit_pair(sw[3]));
                    r.second = 9'(sec);
                    r.year = last_year;
                end
            end else if (!broken) begin
                yr = digit_pair(sw[1]) * 100 + digit_pair(sw[2]);
                last_year = 15'(yr);
                r.kind = KIND_B;
                r.year = last_year;
                r.dut1 = sw[0][3:0];
                r.tai_utc = 8'(digit_pair(sw[3]));
                r.dst = sw[4][3:0];
            end
            frames_due.push_back(r);
            kind_count[r.kind]++;
        endfunction

        function void cmp_field(string field, logic signed [31:0] want,
                                logic signed [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field,
                         want, got);
            end
        endfunction

        function void check_result(t_frame_result got);
            t_frame_result want;
            if (frames_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d", $realtime,
                         got.kind);
                return;
            end
            want = frames_due.pop_front();
            cmp_field("kind", want.kind, got.kind);
            cmp_field("day_of_year", want.day, got.day);
            cmp_field("hour_value", want.hour, got.hour);
            cmp_field("minute_value", want.minute, got.minute);
            cmp_field("second_value", want.second, got.second);
            cmp_field("year_value", want.year, got.year);
            cmp_field("dut1_value", want.dut1, got.dut1);
            cmp_field("tai_utc_value", want.tai_utc, got.tai_utc);
            cmp_field("dst_code", want.dst, got.dst);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               in_op;
    logic [7:0]         in_data;
    logic               cfg_wr_en;
    logic signed [6:0]  cfg_wr_data;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         kind;
    logic [10:0]        day_of_year;
    logic [7:0]         hour_value;
    logic [7:0]         minute_value;
    logic signed [8:0]  second_value;
    logic [14:0]        year_value;
    logic [3:0]         dut1_value;
    logic [7:0]         tai_utc_value;
    logic [3:0]         dst_code;

    chu_frame_scoreboard sb = new();
    bit [7:0]            frame_img [FRAME_LEN];
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  cycles;
    int                  last_offset;

    chu_time_code_frame_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (in_op),
        .i_data_byte     (in_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_kind          (kind),
        .o_day_of_year   (day_of_year),
        .o_hour_value    (hour_value),
        .o_minute_value  (minute_value),
        .o_second_value  (second_value),
        .o_year_value    (year_value),
        .o_dut1_value    (dut1_value),
        .o_tai_utc_value (tai_utc_value),
        .o_dst_code      (dst_code)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        t_frame_result got;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            got.kind = kind;
            got.day = day_of_year;
            got.hour = hour_value;
            got.minute = minute_value;
            got.second = second_value;
            got.year = year_value;
            got.dut1 = dut1_value;
            got.tai_utc = tai_utc_value;
            got.dst = dst_code;
            sb.check_result(got);
        end
    end

    task automatic send_item(logic op, logic [7:0] data_val);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op <= op;
        in_data <= data_val;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        sb.note_byte(op, data_val);
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < FRAME_LEN; i++) send_item(OP_DATA, frame_img[i]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_offset(int value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= 7'(value);
        sb.set_offset(value);
        last_offset = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_sequence();
        int       pick;
        int       j;
        bit [3:0] nib;
        pick = $urandom_range(99);
        if (pick < 87) begin
            for (int i = 0; i < HALF_LEN; i++) frame_img[i] = 8'($urandom_range(255));
            if (pick < 35) begin
                frame_img[0][3:0] = A_MARKER;
            end else if (pick < 45) begin
                nib = 4'($urandom_range(15));
                if (nib == A_MARKER) nib = nib + 4'd1;
                frame_img[0][3:0] = nib;
            end
            for (int i = 0; i < HALF_LEN; i++) begin
                frame_img[i + HALF_LEN] = $urandom_range(1) ? ~frame_img[i] : frame_img[i];
            end
            if (pick < 45) begin
                frame_img[FRAME_LEN - 1] = frame_img[HALF_LEN - 1];
            end else if (pick < 75) begin
                frame_img[FRAME_LEN - 1] = ~frame_img[HALF_LEN - 1];
            end else begin
                j = $urandom_range(HALF_LEN - 1);
                frame_img[j + HALF_LEN] = frame_img[j] ^ 8'($urandom_range(254, 1));
            end
            if ($urandom_range(9) == 0) send_item(OP_RESYNC, 8'($urandom_range(255)));
            send_frame();
        end else begin
            repeat ($urandom_range(9, 1)) send_item(OP_DATA, 8'($urandom_range(255)));
            if ($urandom_range(4) != 0) send_item(OP_RESYNC, 8'($urandom_range(255)));
        end
    endtask

    task automatic run_phase(int snd_pct, int rcv_pct);
        int start;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start = sb.items;
        while (sb.items - start < ITEMS_PER_PHASE) random_sequence();
    endtask

    initial begin
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_op = OP_DATA;
        in_data = 8'h00;
        cfg_wr_en = 1'b0;
        cfg_wr_data = OFFSET_RESET;
        out_stall = 1'b0;
        send_idle_pct = 38;
        recv_idle_pct = 50;
        last_offset = OFFSET_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < HALF_LEN; i++) begin
            frame_img[i] = 8'hFF;
            frame_img[i + HALF_LEN] = 8'h00;
        end
        send_frame();
        send_item(OP_DATA, 8'h12);
        send_item(OP_DATA, 8'h34);
        send_item(OP_RESYNC, 8'hA5);
        frame_img[0] = 8'hF6;
        frame_img[HALF_LEN] = 8'hF6;
        for (int i = 1; i < HALF_LEN; i++) begin
            frame_img[i] = 8'hFF;
            frame_img[i + HALF_LEN] = 8'hFF;
        end
        send_frame();
        drain();

        write_offset(-59);
        run_phase(38, 50);
        drain();
        write_offset(59);
        run_phase(50, 38);
        drain();
        write_offset(int'($urandom_range(118)) - 59);
        run_phase(0, 0);
        drain();
        repeat (10) @(posedge clk);

        $display("Sent %0d transactions; checked %0d time, %0d info and %0d rejected frames.",
                 sb.items, sb.kind_count[KIND_A], sb.kind_count[KIND_B],
                 sb.kind_count[KIND_REJECT]);
        $display("Seconds offset went through 2, -59, 59 and %0d.", last_offset);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
